// ===== rtl/rpr_pkg.sv =====
// ---------------------------------------------------------------------------
// rpr_pkg: shared types and helpers for the rotary position rotate block
// Holds the bf16 product term type, the function that forms it and the lane constants.
// ---------------------------------------------------------------------------
package rpr_pkg;

    localparam int BF_W      = 16;
    localparam int MAX_LANES = 4;
    localparam int LANES_DEF = 4;
    localparam int PACK_W    = BF_W * MAX_LANES;

    localparam logic [31:0] FP32_QNAN = 32'h7FC0_0000;
    localparam logic [31:0] FP32_INF  = 32'h7F80_0000;
    localparam logic [15:0] BF16_QNAN = 16'h7FC0;

    typedef enum logic [1:0] {
        K_ZERO = 2'd0,
        K_FIN  = 2'd1,
        K_INF  = 2'd2,
        K_NAN  = 2'd3
    } t_kind;

    // value = m * 2^e when kind is K_FIN
    typedef struct packed {
        t_kind              kind;
        logic               sign;
        logic [15:0]        m;
        logic signed [10:0] e;
    } t_term;

    // Exact bf16 product with subnormal flush and NaN/inf classification
    function automatic t_term bf_mul(input logic [15:0] x, input logic [15:0] y);
        t_term t;
        logic  nanx, nany, infx, infy, zx, zy;
        nanx = (x[14:7] == 8'hFF) && (x[6:0] != 7'd0);
        nany = (y[14:7] == 8'hFF) && (y[6:0] != 7'd0);
        infx = (x[14:7] == 8'hFF) && (x[6:0] == 7'd0);
        infy = (y[14:7] == 8'hFF) && (y[6:0] == 7'd0);
        zx   = (x[14:7] == 8'd0);
        zy   = (y[14:7] == 8'd0);
        t.sign = x[15] ^ y[15];
        t.m    = {1'b1, x[6:0]} * {1'b1, y[6:0]};
        t.e    = $signed(11'({3'd0, x[14:7]}) + 11'({3'd0, y[14:7]}) - 11'd268);
        if (nanx || nany || (infx && zy) || (infy && zx)) begin
            t.kind = K_NAN;
        end else if (infx || infy) begin
            t.kind = K_INF;
        end else if (zx || zy) begin
            t.kind = K_ZERO;
        end else begin
            t.kind = K_FIN;
        end
        return t;
    endfunction

endpackage

// ===== rtl/rpr_dot.sv =====
// ---------------------------------------------------------------------------
// rpr_dot: one lane datapath, x0*y0 + x1*y1 in bf16
// Four stages: multiply, align and add, normalise, round to fp32 then bf16.
// ---------------------------------------------------------------------------
module rpr_dot
    import rpr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_x0,
    input  logic [15:0] i_y0,
    input  logic [15:0] i_x1,
    input  logic [15:0] i_y1,
    output logic [15:0] o_res
);

    // stage 1: products
    t_term r1_p, r1_q;

    // stage 2: aligned sum
    logic [56:0]        r2_m;
    logic               r2_sign;
    logic signed [10:0] r2_e;
    logic               r2_spec;
    logic [31:0]        r2_spec_val;

    // stage 3: normalised significand
    logic [23:0]        r3_q;
    logic               r3_g, r3_st, r3_sign, r3_spec;
    logic signed [10:0] r3_ex;
    logic [31:0]        r3_spec_val;

    logic [15:0]        r4_res;

    // ---- stage 2 logic
    t_term              big, sml;
    logic               swap;
    logic signed [10:0] d;
    logic [5:0]         dc;
    logic [55:0]        m1, m2, sh_full, sh_out;
    logic [56:0]        n_m;
    logic               n_sign, n_spec;
    logic [31:0]        n_spec_val;

    always_comb begin
        swap = (r1_p.kind == K_ZERO) || ((r1_q.kind == K_FIN) && (r1_q.e > r1_p.e));
        big  = swap ? r1_q : r1_p;
        sml  = swap ? r1_p : r1_q;
        d    = big.e - sml.e;
        dc   = (d > 11'sd56) ? 6'd56 : d[5:0];
        m1   = {big.m, 40'd0};
        sh_full = {sml.m, 40'd0};
        sh_out  = sh_full >> dc;
        if (sml.kind == K_FIN) begin
            m2 = sh_out | {55'd0, ((sh_out << dc) != sh_full)};
        end else begin
            m2 = 56'd0;
        end
        if (big.sign == sml.sign) begin
            n_m    = {1'b0, m1} + {1'b0, m2};
            n_sign = big.sign;
        end else if (m1 >= m2) begin
            n_m    = {1'b0, m1 - m2};
            n_sign = big.sign;
        end else begin
            n_m    = {1'b0, m2 - m1};
            n_sign = sml.sign;
        end
        n_spec     = 1'b1;
        n_spec_val = 32'd0;
        if (r1_p.kind == K_NAN || r1_q.kind == K_NAN) begin
            n_spec_val = FP32_QNAN;
        end else if (r1_p.kind == K_INF && r1_q.kind == K_INF && r1_p.sign != r1_q.sign) begin
            n_spec_val = FP32_QNAN;
        end else if (r1_p.kind == K_INF) begin
            n_spec_val = {r1_p.sign, 31'd0} | FP32_INF;
        end else if (r1_q.kind == K_INF) begin
            n_spec_val = {r1_q.sign, 31'd0} | FP32_INF;
        end else if (r1_p.kind == K_ZERO && r1_q.kind == K_ZERO) begin
            n_spec_val = {r1_p.sign & r1_q.sign, 31'd0};
        end else begin
            n_spec = 1'b0;
        end
    end

    // ---- stage 3 logic: leading one search and normalise
    logic [5:0]  lz;
    logic [56:0] mn;
    always_comb begin
        lz = 6'd0;
        for (int k = 0; k < 57; k++) begin
            if (r2_m[k]) begin
                lz = 6'(56 - k);
            end
        end
        mn = r2_m << lz;
    end

    // ---- stage 4 logic: round to fp32, then to bf16
    logic [24:0]        qr;
    logic signed [10:0] ex2;
    logic [31:0]        fp;
    logic [32:0]        bsum;
    always_comb begin
        qr  = {1'b0, r3_q} + 25'(r3_g && (r3_st || r3_q[0]));
        ex2 = r3_ex + (qr[24] ? 11'sd1 : 11'sd0);
        if (r3_spec) begin
            fp = r3_spec_val;
        end else if (ex2 > 11'sd127) begin
            fp = {r3_sign, 31'd0} | FP32_INF;
        end else if (ex2 < -11'sd126) begin
            fp = {r3_sign, 31'd0};
        end else begin
            fp = {r3_sign, 8'(ex2 + 11'sd127), qr[24] ? 23'd0 : qr[22:0]};
        end
        bsum = {1'b0, fp} + 33'h7FFF + {32'd0, fp[16]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p        <= bf_mul(i_x0, i_y0);
            r1_q        <= bf_mul(i_x1, i_y1);
            r2_m        <= n_m;
            r2_sign     <= n_sign;
            r2_e        <= big.e;
            r2_spec     <= n_spec;
            r2_spec_val <= n_spec_val;
            r3_q        <= mn[56:33];
            r3_g        <= mn[32];
            r3_st       <= |mn[31:0];
            r3_sign     <= r2_sign;
            r3_ex       <= r2_e + 11'sd16 - $signed({5'd0, lz});
            r3_spec     <= r2_spec || (r2_m == 57'd0);
            r3_spec_val <= r2_spec ? r2_spec_val : 32'd0;
            r4_res      <= bsum[31:16];
        end
    end

    assign o_res = r4_res;

endmodule

// ===== rtl/rotary_position_rotate_bf16.sv =====
// ---------------------------------------------------------------------------
// rotary_position_rotate_bf16: rotate-half rotary position step, bf16 lanes
// Per lane: y_first = a*cos - b*sin, y_second = a*sin + b*cos, exact
// products, one rounding to fp32 then one to bf16, subnormals flushed.
// ---------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------
//  in      | i_valid / o_stall     | i_x_first i_x_second i_cos_pack i_sin_pack
//  out     | o_valid / i_stall     | o_y_first o_y_second
//
//  One beat in per cycle while the output beat is not stalled; the result
//  is on offer once the beat has passed the four register stages of each
//  lane datapath, the first loaded at the accepting edge.
//  Reset (synchronous, active low) empties the valid pipe only.
//  A stalled output beat freezes the whole pipe; the input then sees
//  o_stall, otherwise beats keep flowing at one per cycle.
//  Lanes from LANES upwards read as zero on both outputs.
// ---------------------------------------------------------------------------
module rotary_position_rotate_bf16
    import rpr_pkg::*;
#(
    parameter int LANES = LANES_DEF
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [PACK_W-1:0] i_x_first,
    input  logic [PACK_W-1:0] i_x_second,
    input  logic [PACK_W-1:0] i_cos_pack,
    input  logic [PACK_W-1:0] i_sin_pack,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [PACK_W-1:0] o_y_first,
    output logic [PACK_W-1:0] o_y_second
);

    // valid bit per pipeline stage; the last one is the output beat
    logic [3:0] r_vld;
    logic       pipe_en;

    // hold everything while the output beat is stalled
    assign pipe_en = !(r_vld[3] && i_stall);
    assign o_stall = !pipe_en;
    assign o_valid = r_vld[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 4'd0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    logic [BF_W-1:0] lane_f [MAX_LANES];
    logic [BF_W-1:0] lane_s [MAX_LANES];

    for (genvar g = 0; g < MAX_LANES; g++) begin : g_lane
        if (g < LANES) begin : g_on
            logic [BF_W-1:0] a, b, c, s;
            assign a = i_x_first [BF_W*g +: BF_W];
            assign b = i_x_second[BF_W*g +: BF_W];
            assign c = i_cos_pack[BF_W*g +: BF_W];
            assign s = i_sin_pack[BF_W*g +: BF_W];

            // a*c + (-b)*s : flip b's sign for the subtracted product
            rpr_dot u_first (
                .i_clk (i_clk),
                .i_en  (pipe_en),
                .i_x0  (a),
                .i_y0  (c),
                .i_x1  ({~b[BF_W-1], b[BF_W-2:0]}),
                .i_y1  (s),
                .o_res (lane_f[g])
            );

            // a*s + b*c
            rpr_dot u_second (
                .i_clk (i_clk),
                .i_en  (pipe_en),
                .i_x0  (a),
                .i_y0  (s),
                .i_x1  (b),
                .i_y1  (c),
                .o_res (lane_s[g])
            );
        end else begin : g_off
            // unused lane: drive zero into the merge
            assign lane_f[g] = '0;
            assign lane_s[g] = '0;
        end
    end

    // merge lane results into the packed output words
    always_comb begin
        for (int k = 0; k < MAX_LANES; k++) begin
            o_y_first [BF_W*k +: BF_W] = lane_f[k];
            o_y_second[BF_W*k +: BF_W] = lane_s[k];
        end
    end

    // stall only ever comes back while a result beat is on offer
    a_stall_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no output beat pending");

    // a NaN on y_first lane 0 must be the canonical quiet NaN
    a_nan_canonical: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_y_first[14:7] == 8'hFF && o_y_first[6:0] != 7'd0)
            |-> (o_y_first[15:0] == BF16_QNAN))
        else $error("non-canonical NaN on y_first lane 0");

    // an accepted beat with no stall anywhere reaches the output as a valid beat
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !o_stall ##1 !o_stall ##1 !o_stall |=> o_valid)
        else $error("accepted beat did not reach the output");

endmodule

// ===== dv/rotary_rotate_checker.sv =====
// ---------------------------------------------------------------------------
// rotary_rotate_checker: predicts and checks the rotary rotate result stream
// Watches both channels, computes the expected bf16 lanes for every accepted
// input beat and compares each output beat against the oldest expectation.
// ---------------------------------------------------------------------------
module rotary_rotate_checker
    import rpr_pkg::*;
#(
    parameter int LANES = LANES_DEF
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_stall_in,
    input  logic [PACK_W-1:0] i_x_first,
    input  logic [PACK_W-1:0] i_x_second,
    input  logic [PACK_W-1:0] i_cos_pack,
    input  logic [PACK_W-1:0] i_sin_pack,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [PACK_W-1:0] i_y_first,
    input  logic [PACK_W-1:0] i_y_second,
    output int                o_errors,
    output int                o_pending,
    output int                o_in_beats,
    output int                o_out_beats
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_kind       kind;
        logic        sign;
        logic [63:0] mant;
        int          expo;
    } t_prod;

    logic [PACK_W-1:0] rot_first_q[$];
    logic [PACK_W-1:0] rot_second_q[$];

    function automatic t_prod prod_of(logic [15:0] x, logic [15:0] y, logic neg);
        t_prod p;
        logic  nx, ny, ix, iy, zx, zy;
        nx = (x[14:7] == 8'hFF) && (x[6:0] != 0);
        ny = (y[14:7] == 8'hFF) && (y[6:0] != 0);
        ix = (x[14:7] == 8'hFF) && (x[6:0] == 0);
        iy = (y[14:7] == 8'hFF) && (y[6:0] == 0);
        zx = (x[14:7] == 0);
        zy = (y[14:7] == 0);
        p.sign = x[15] ^ y[15] ^ neg;
        p.mant = 0;
        p.expo = 0;
        if (nx || ny || (ix && zy) || (iy && zx)) p.kind = K_NAN;
        else if (ix || iy) p.kind = K_INF;
        else if (zx || zy) p.kind = K_ZERO;
        else begin
            p.kind = K_FIN;
            p.mant = 64'({1'b1, x[6:0]}) * 64'({1'b1, y[6:0]});
            p.expo = int'(x[14:7]) + int'(y[14:7]) - 268;
        end
        return p;
    endfunction

    function automatic logic [31:0] round_single(logic sgn, logic [63:0] m, int e);
        int          len, ex, sh;
        logic [63:0] q, rem, half;
        len = 0;
        while (len < 64 && (m >> len) != 0) len++;
        ex = e + len - 1;
        if (len > 24) begin
            sh   = len - 24;
            rem  = m & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            q    = m >> sh;
            if (rem > half || (rem == half && q[0])) q++;
            if (q == (64'd1 << 24)) begin
                q = q >> 1;
                ex++;
            end
        end else begin
            q = m << (24 - len);
        end
        if (ex > 127) return {sgn, 31'h7F80_0000};
        if (ex < -126) return {sgn, 31'd0};
        return {sgn, 8'(ex + 127), q[22:0]};
    endfunction

    function automatic logic [31:0] sum_single(t_prod p, t_prod q);
        t_prod       hi, lo;
        logic [63:0] m1, m2, m;
        logic        sgn;
        int          d, sh;
        if (p.kind == K_NAN || q.kind == K_NAN) return FP32_QNAN;
        if (p.kind == K_INF && q.kind == K_INF && p.sign != q.sign) return FP32_QNAN;
        if (p.kind == K_INF) return {p.sign, 31'h7F80_0000};
        if (q.kind == K_INF) return {q.sign, 31'h7F80_0000};
        if (p.kind == K_ZERO && q.kind == K_ZERO) return {p.sign & q.sign, 31'd0};
        if (p.kind == K_ZERO) return round_single(q.sign, q.mant, q.expo);
        if (q.kind == K_ZERO) return round_single(p.sign, p.mant, p.expo);
        if (p.expo >= q.expo) begin
            hi = p; lo = q;
        end else begin
            hi = q; lo = p;
        end
        d  = hi.expo - lo.expo;
        m1 = hi.mant << 40;
        if (d <= 40) m2 = lo.mant << (40 - d);
        else begin
            sh = d - 40;
            if (sh >= 17) m2 = 1;
            else m2 = (lo.mant >> sh) | 64'((lo.mant & ((64'd1 << sh) - 1)) != 0);
        end
        if (hi.sign == lo.sign) begin
            m = m1 + m2; sgn = hi.sign;
        end else if (m1 >= m2) begin
            m = m1 - m2; sgn = hi.sign;
        end else begin
            m = m2 - m1; sgn = lo.sign;
        end
        if (m == 0) return 32'd0;
        return round_single(sgn, m, hi.expo - 40);
    endfunction

    function automatic logic [15:0] to_bf16(logic [31:0] b);
        logic [32:0] t;
        if (b[30:0] > 31'h7F80_0000) return BF16_QNAN;
        t = 33'(b) + 33'h7FFF + 33'(b[16]);
        return t[31:16];
    endfunction

    always @(posedge i_clk) begin
        logic [PACK_W-1:0] ef, es;
        logic [15:0]       a, b, c, s;
        if (!i_rst_n) begin
            o_errors    <= 0;
            o_in_beats  <= 0;
            o_out_beats <= 0;
        end else begin
            if (i_valid && !i_stall_in) begin
                ef = '0;
                es = '0;
                for (int i = 0; i < LANES; i++) begin
                    a = i_x_first[16*i +: 16];
                    b = i_x_second[16*i +: 16];
                    c = i_cos_pack[16*i +: 16];
                    s = i_sin_pack[16*i +: 16];
                    ef[16*i +: 16] = to_bf16(sum_single(prod_of(a, c, 0), prod_of(b, s, 1)));
                    es[16*i +: 16] = to_bf16(sum_single(prod_of(a, s, 0), prod_of(b, c, 0)));
                end
                rot_first_q.push_back(ef);
                rot_second_q.push_back(es);
                o_in_beats <= o_in_beats + 1;
            end
            if (i_out_valid && !i_out_stall) begin
                o_out_beats <= o_out_beats + 1;
                if (rot_first_q.size() == 0) begin
                    $display("%0t: unexpected beat y_first=%h y_second=%h",
                             $time, i_y_first, i_y_second);
                    o_errors <= o_errors + 1;
                end else begin
                    ef = rot_first_q.pop_front();
                    es = rot_second_q.pop_front();
                    if (ef !== i_y_first || es !== i_y_second) begin
                        $display("%0t: mismatch y_first exp %h got %h, y_second exp %h got %h",
                                 $time, ef, i_y_first, es, i_y_second);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= rot_first_q.size();
    end

endmodule

// ===== dv/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench: stimulus and verdict for the rotary position rotate block
// Drives directed and random bf16 lanes through the block under three idling
// regimes, with a long output hold-off and drain pauses, then reports.
// ---------------------------------------------------------------------------
module testbench
    import rpr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 20000;
    localparam int LATENCY  = 4;

    logic              clk, rst_n;
    logic              in_valid, in_stall, out_valid, out_stall;
    logic [PACK_W-1:0] x_first, x_second, cos_pack, sin_pack, y_first, y_second;
    int                errors, pending, in_beats, out_beats;
    int                src_idle_pct, snk_idle_pct;
    int                idle_cycles;
    bit                hold_off, timed_out;

    rotary_position_rotate_bf16 i_dut (
        .i_clk     (clk),      .i_rst_n   (rst_n),
        .i_valid   (in_valid), .o_stall   (in_stall),
        .i_x_first (x_first),  .i_x_second(x_second),
        .i_cos_pack(cos_pack), .i_sin_pack(sin_pack),
        .o_valid   (out_valid),.i_stall   (out_stall),
        .o_y_first (y_first),  .o_y_second(y_second)
    );

    rotary_rotate_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_stall_in(in_stall),
        .i_x_first(x_first), .i_x_second(x_second),
        .i_cos_pack(cos_pack), .i_sin_pack(sin_pack),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_y_first(y_first), .i_y_second(y_second),
        .o_errors(errors), .o_pending(pending),
        .o_in_beats(in_beats), .o_out_beats(out_beats)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Receiver: stall at random, or hold off entirely while hold_off is set.
    always @(negedge clk) begin
        out_stall <= hold_off || ($urandom_range(99) < snk_idle_pct);
    end

    // Watchdog: count cycles with no beat on either channel.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Pick a bf16 value: mostly ordinary, sometimes zero, subnormal, inf, NaN,
    // or extremes of the exponent so that overflow and tiny sums occur.
    function automatic logic [15:0] pick_bf16();
        logic [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(15))
            0:  v[14:7] = 8'h00;
            1:  v[14:0] = 15'h7F80;
            2:  v[14:7] = 8'hFF;
            3:  v[14:7] = 8'(8'hF0 + $urandom_range(14));
            4:  v[14:7] = 8'($urandom_range(1, 12));
            5, 6: ;
            default: v[14:7] = 8'($urandom_range(110, 135));
        endcase
        return v;
    endfunction

    function automatic logic [63:0] pick_pack();
        return {pick_bf16(), pick_bf16(), pick_bf16(), pick_bf16()};
    endfunction

    // Offer one beat and hold it until accepted; valid stays high afterwards
    // so that the next beat can follow with no gap.
    task automatic send_beat(logic [63:0] a, logic [63:0] b, logic [63:0] c, logic [63:0] s);
        if ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 0;
            @(negedge clk);
            while ($urandom_range(99) < src_idle_pct) @(negedge clk);
        end
        in_valid <= 1;
        x_first  <= a;
        x_second <= b;
        cos_pack <= c;
        sin_pack <= s;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        do @(posedge clk); while (pending != 0);
        repeat (LATENCY + 2) @(posedge clk);
        @(negedge clk);
    endtask

    initial begin
        in_valid = 0; hold_off = 0;
        x_first = 0; x_second = 0; cos_pack = 0; sin_pack = 0;
        src_idle_pct = 0; snk_idle_pct = 0;
        rst_n = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: extremes, signed zeros, cancellation, subnormals, inf, NaN.
        send_beat('0, '0, '0, '0);
        send_beat('1, '1, '1, '1);
        send_beat({4{16'h8000}}, {4{16'h0000}}, {4{16'h8000}}, {4{16'h8000}});
        send_beat({4{16'h3F80}}, {4{16'h3F80}}, {4{16'h3F80}}, {4{16'h3F80}});
        send_beat({4{16'h0040}}, {4{16'h8001}}, {4{16'h3F80}}, {4{16'h3F80}});
        send_beat({4{16'h7F80}}, {4{16'h3F80}}, {4{16'h0000}}, {4{16'h3F80}});
        send_beat({4{16'h7F80}}, {4{16'h7F80}}, {4{16'h3F80}}, {4{16'h3F80}});
        send_beat({4{16'h7FC1}}, {4{16'h3F80}}, {4{16'h3F80}}, {4{16'h3F80}});
        send_beat({4{16'h7F7F}}, {4{16'h7F7F}}, {4{16'h7F7F}}, {4{16'hFF7F}});
        send_beat({4{16'h7F7F}}, {4{16'h7F7F}}, {4{16'h3F80}}, {4{16'h3F80}});
        send_beat({4{16'h0080}}, {4{16'h0080}}, {4{16'h0080}}, {4{16'h0080}});
        send_beat({4{16'h2080}}, {4{16'h2080}}, {4{16'h1F80}}, {4{16'h1F81}});
        send_beat({4{16'h3F81}}, {4{16'h3F80}}, {4{16'h3F7F}}, {4{16'hBF80}});
        send_beat(64'h5555_AAAA_FFFF_0000, 64'hAAAA_5555_0000_FFFF,
                  64'h3F80_BF80_7F80_0001, 64'hFF80_7FC0_3F00_8000);
        drain();

        // Long receiver hold-off while the sender keeps offering beats.
        fork
            begin
                hold_off = 1;
                repeat (60) @(posedge clk);
                @(negedge clk);
                hold_off = 0;
            end
            repeat (30) send_beat(pick_pack(), pick_pack(), pick_pack(), pick_pack());
        join
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 63 : 0;
            snk_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 13 : 0;
            for (int n = 0; n < 400; n++) begin
                send_beat(pick_pack(), pick_pack(), pick_pack(), pick_pack());
                if (n == 200) drain();
            end
        end

        in_valid <= 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        timed_out = 1;
        for (int w = 0; w < WATCHDOG; w++) begin
            @(posedge clk);
            if (pending == 0) begin
                timed_out = 0;
                break;
            end
        end
        repeat (LATENCY + 4) @(posedge clk);
        $display("Run covered %0d input beats and %0d result beats with special values,",
                 in_beats, out_beats);
        $display("a long output hold-off, drain pauses and three idling regimes.");
        if (!timed_out && errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
